FILE: hdl/goi_pkg.sv
`default_nettype none
package goi_pkg;

    // command codes carried in s_tuser
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_CHECK = 2'd2;
    localparam logic [1:0] CMD_FETCH = 2'd3;

    // status codes carried in m_tuser
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // stream and register widths
    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 72;
    localparam int ADDR_W   = 3;

    // register indexes (paddr[2])
    localparam logic REG_MAX_POS   = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KEY_RD,
        S_KEY_CMP,
        S_CNT,
        S_MUL1,
        S_MUL2,
        S_POS_RD,
        S_POS_OUT,
        S_EMIT
    } fsm_t;

endpackage
`default_nettype wire

FILE: hdl/group_occurrence_index_core.sv
`default_nettype none
// Group occurrence index: a table of up to GROUPS groups keyed by 64-bit id, with
// per-group row counts and up to POSITIONS stored row positions. Commands on s_tuser:
// clear, add, check, fetch. The key search walks the groups in arrival order through
// one key memory, with a read state and a compare state per group visited; check adds
// the multiply states S_MUL1 and S_MUL2, and fetch spends a read state and an output
// state per returned position in place of the single result state. Clear needs no
// sweep: a fill count marks the live groups. One item is worked on at a time; a result
// register lets the next item enter while the last result still waits on m_tready.
module group_occurrence_index_core
    import goi_pkg::*;
#(
    parameter int GROUPS    = 256,
    parameter int POSITIONS = 16
) (
    input  wire  logic                aclk,
    input  wire  logic                aresetn,
    // command stream handshake
    input  wire  logic                s_tvalid,
    output logic                      s_tready,
    // group key, row pos, seen count, sample total, boost count
    input  wire  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  wire  logic [1:0]          s_tuser,
    output logic                      m_tvalid,
    input  wire  logic                m_tready,
    // group_rows, underrepresented, boost_position, position_valid, zero pad
    output logic [M_DATA_W-1:0]       m_tdata,
    // status
    output logic [1:0]                m_tuser,
    output logic                      m_tlast,
    input  wire  logic                psel,
    input  wire  logic                penable,
    input  wire  logic                pwrite,
    input  wire  logic [ADDR_W-1:0]   paddr,
    input  wire  logic [31:0]         pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    localparam int GW  = $clog2(GROUPS);
    localparam int PW  = $clog2(POSITIONS + 1);
    localparam int PD  = GROUPS * POSITIONS;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int CW  = 32 + PW;

    fsm_t state_reg, state_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [63:0]      key_reg, key_next;
    logic [31:0]      rowpos_reg, rowpos_next;
    logic [31:0]      obs_reg, obs_next;
    logic [31:0]      sample_reg, sample_next;
    logic [15:0]      boost_reg, boost_next;
    logic [GW:0]      idx_reg, idx_next;
    logic [GW:0]      used_reg, used_next;
    logic [31:0]      total_reg, total_next;
    logic [4:0]       maxpos_reg, maxpos_next;
    logic [15:0]      thr_reg, thr_next;
    logic [31:0]      rows_reg, rows_next;
    logic [63:0]      b_reg, b_next;
    logic [63:0]      a_reg, a_next;
    logic [47:0]      plo_reg, plo_next;
    logic [47:0]      phi_reg, phi_next;
    logic [PW-1:0]    take_reg, take_next;
    logic [PW-1:0]    pi_reg, pi_next;
    logic [1:0]       res_st_reg, res_st_next;
    logic [31:0]      res_rows_reg, res_rows_next;
    logic             res_flag_reg, res_flag_next;

    logic             out_v_reg, out_v_next;
    logic [1:0]       out_st_reg, out_st_next;
    logic [31:0]      out_rows_reg, out_rows_next;
    logic             out_flag_reg, out_flag_next;
    logic [31:0]      out_pos_reg, out_pos_next;
    logic             out_pv_reg, out_pv_next;
    logic             out_last_reg, out_last_next;

    // memory ports
    logic             key_we, key_re;
    logic [GW-1:0]    key_waddr, key_raddr;
    logic [63:0]      key_rdata;
    logic             cnt_we, cnt_re;
    logic [GW-1:0]    cnt_waddr, cnt_raddr;
    logic [CW-1:0]    cnt_wdata, cnt_rdata;
    logic             pos_we, pos_re;
    logic [PAW-1:0]   pos_waddr, pos_raddr;
    logic [31:0]      pos_wdata, pos_rdata;

    logic             s_fire, can_load, scan_end, key_hit, tbl_full;
    logic [PW-1:0]    cap, cnt_stored, take_c;
    logic [31:0]      cnt_rows;
    logic [PAW-1:0]   base_idx, base_used;
    logic [79:0]      rhs, lhs;
    logic             flag_c, cfg_wr;

    goi_ram #(.WIDTH(64), .DEPTH(GROUPS)) u_key_ram (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
        .re(key_re), .raddr(key_raddr), .rdata(key_rdata)
    );

    goi_ram #(.WIDTH(CW), .DEPTH(GROUPS)) u_cnt_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    goi_ram #(.WIDTH(32), .DEPTH(PD)) u_pos_ram (
        .aclk(aclk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .re(pos_re), .raddr(pos_raddr), .rdata(pos_rdata)
    );

    // shared decode
    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign can_load   = !out_v_reg || m_tready;
    assign scan_end   = (idx_reg == used_reg);
    assign key_hit    = (key_rdata == key_reg);
    assign tbl_full   = (used_reg == (GW+1)'(GROUPS));
    assign cap        = PW'((32'(maxpos_reg) > 32'(POSITIONS)) ? 32'(POSITIONS)
                                                               : 32'(maxpos_reg));
    assign cnt_rows   = cnt_rdata[31:0];
    assign cnt_stored = cnt_rdata[CW-1:32];
    assign take_c     = (32'(boost_reg) < 32'(cnt_stored)) ? PW'(boost_reg) : cnt_stored;
    assign base_idx   = PAW'(idx_reg[GW-1:0]) * PAW'(POSITIONS);
    assign base_used  = PAW'(used_reg[GW-1:0]) * PAW'(POSITIONS);

    // flag: 2*b >= total and observed*total*4096 < threshold*b
    assign rhs    = {phi_reg, 32'd0} + 80'(plo_reg);
    assign lhs    = {4'd0, a_reg, 12'd0};
    assign flag_c = (total_reg != 32'd0) && (sample_reg != 32'd0) && (thr_reg != 16'd0)
                    && (rows_reg != 32'd0) && ({b_reg, 1'b0} >= 65'(total_reg))
                    && (lhs < rhs);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == CMD_CLEAR) ? S_EMIT : S_KEY_RD;
                end
            end
            S_KEY_RD: begin
                state_next = scan_end ? S_EMIT : S_KEY_CMP;
            end
            S_KEY_CMP: begin
                state_next = key_hit ? S_CNT : S_KEY_RD;
            end
            S_CNT: begin
                if (cmd_reg == CMD_CHECK) begin
                    state_next = S_MUL1;
                end else if (cmd_reg == CMD_FETCH && take_c != '0) begin
                    state_next = S_POS_RD;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_MUL1: begin
                state_next = S_MUL2;
            end
            S_MUL2: begin
                state_next = S_EMIT;
            end
            S_POS_RD: begin
                state_next = S_POS_OUT;
            end
            S_POS_OUT: begin
                if (can_load) begin
                    state_next = (pi_reg + PW'(1) == take_reg) ? S_IDLE : S_POS_RD;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        rowpos_next   = rowpos_reg;
        obs_next      = obs_reg;
        sample_next   = sample_reg;
        boost_next    = boost_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        total_next    = total_reg;
        rows_next     = rows_reg;
        b_next        = b_reg;
        a_next        = a_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        take_next     = take_reg;
        pi_next       = pi_reg;
        res_st_next   = res_st_reg;
        res_rows_next = res_rows_reg;
        res_flag_next = res_flag_reg;

        out_v_next    = out_v_reg && !m_tready;
        out_st_next   = out_st_reg;
        out_rows_next = out_rows_reg;
        out_flag_next = out_flag_reg;
        out_pos_next  = out_pos_reg;
        out_pv_next   = out_pv_reg;
        out_last_next = out_last_reg;

        key_we    = 1'b0;
        key_re    = 1'b0;
        key_waddr = used_reg[GW-1:0];
        key_raddr = idx_reg[GW-1:0];
        cnt_we    = 1'b0;
        cnt_re    = 1'b0;
        cnt_waddr = idx_reg[GW-1:0];
        cnt_raddr = idx_reg[GW-1:0];
        cnt_wdata = '0;
        pos_we    = 1'b0;
        pos_re    = 1'b0;
        pos_waddr = base_idx;
        pos_raddr = base_idx + PAW'(pi_reg);
        pos_wdata = rowpos_reg;

        unique case (state_reg)
            S_IDLE: begin
                // latch the item and start the search
                if (s_fire) begin
                    cmd_next      = s_tuser;
                    key_next      = s_tdata[63:0];
                    rowpos_next   = s_tdata[95:64];
                    obs_next      = s_tdata[127:96];
                    sample_next   = s_tdata[159:128];
                    boost_next    = s_tdata[175:160];
                    idx_next      = '0;
                    res_st_next   = ST_OK;
                    res_rows_next = '0;
                    res_flag_next = 1'b0;
                    if (s_tuser == CMD_CLEAR) begin
                        used_next  = '0;
                        total_next = '0;
                    end else if (s_tuser == CMD_ADD && total_reg != 32'hFFFF_FFFF) begin
                        total_next = total_reg + 32'd1;
                    end
                end
            end
            S_KEY_RD: begin
                if (!scan_end) begin
                    key_re = 1'b1;
                end else if (cmd_reg != CMD_ADD) begin
                    res_st_next = ST_NOTFOUND;
                end else if (tbl_full) begin
                    res_st_next = ST_FULL;
                end else begin
                    // create the group in the next free entry
                    key_we        = 1'b1;
                    cnt_we        = 1'b1;
                    cnt_waddr     = used_reg[GW-1:0];
                    cnt_wdata     = {((cap != '0) ? PW'(1) : PW'(0)), 32'd1};
                    pos_we        = (cap != '0);
                    pos_waddr     = base_used;
                    used_next     = used_reg + (GW+1)'(1);
                    res_rows_next = 32'd1;
                end
            end
            S_KEY_CMP: begin
                if (key_hit) begin
                    cnt_re = 1'b1;
                end else begin
                    idx_next = idx_reg + (GW+1)'(1);
                end
            end
            S_CNT: begin
                rows_next = cnt_rows;
                if (cmd_reg == CMD_ADD) begin
                    // count the row, keep its position while room remains
                    res_rows_next = (cnt_rows != 32'hFFFF_FFFF) ? cnt_rows + 32'd1 : cnt_rows;
                    cnt_we        = 1'b1;
                    pos_waddr     = base_idx + PAW'(cnt_stored);
                    if (cnt_stored < cap) begin
                        pos_we    = 1'b1;
                        cnt_wdata = {cnt_stored + PW'(1), res_rows_next};
                    end else begin
                        cnt_wdata = {cnt_stored, res_rows_next};
                    end
                end else if (cmd_reg == CMD_CHECK) begin
                    b_next = 64'(cnt_rows) * 64'(sample_reg);
                    a_next = 64'(obs_reg) * 64'(total_reg);
                end else begin
                    take_next = take_c;
                    pi_next   = '0;
                end
            end
            S_MUL1: begin
                plo_next = 48'(b_reg[31:0]) * 48'(thr_reg);
                phi_next = 48'(b_reg[63:32]) * 48'(thr_reg);
            end
            S_MUL2: begin
                res_rows_next = rows_reg;
                res_flag_next = flag_c;
            end
            S_POS_RD: begin
                pos_re = 1'b1;
            end
            S_POS_OUT: begin
                // emit one stored position
                if (can_load) begin
                    out_v_next    = 1'b1;
                    out_st_next   = ST_OK;
                    out_rows_next = '0;
                    out_flag_next = 1'b0;
                    out_pos_next  = pos_rdata;
                    out_pv_next   = 1'b1;
                    out_last_next = (pi_reg + PW'(1) == take_reg);
                    pi_next       = pi_reg + PW'(1);
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    out_v_next    = 1'b1;
                    out_st_next   = res_st_reg;
                    out_rows_next = res_rows_reg;
                    out_flag_next = res_flag_reg;
                    out_pos_next  = '0;
                    out_pv_next   = 1'b0;
                    out_last_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // configuration writes
    assign cfg_wr = psel && penable && pwrite && pready;
    always_comb begin
        maxpos_next = maxpos_reg;
        thr_next    = thr_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_MAX_POS:   maxpos_next = pwdata[4:0];
                REG_THRESHOLD: thr_next    = pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, thr_reg} : {27'd0, maxpos_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            total_reg  <= '0;
            maxpos_reg <= 5'd16;
            thr_reg    <= 16'd4096;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            total_reg  <= total_next;
            maxpos_reg <= maxpos_next;
            thr_reg    <= thr_next;
            out_v_reg  <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        rowpos_reg   <= rowpos_next;
        obs_reg      <= obs_next;
        sample_reg   <= sample_next;
        boost_reg    <= boost_next;
        idx_reg      <= idx_next;
        rows_reg     <= rows_next;
        b_reg        <= b_next;
        a_reg        <= a_next;
        plo_reg      <= plo_next;
        phi_reg      <= phi_next;
        take_reg     <= take_next;
        pi_reg       <= pi_next;
        res_st_reg   <= res_st_next;
        res_rows_reg <= res_rows_next;
        res_flag_reg <= res_flag_next;
        out_st_reg   <= out_st_next;
        out_rows_reg <= out_rows_next;
        out_flag_reg <= out_flag_next;
        out_pos_reg  <= out_pos_next;
        out_pv_reg   <= out_pv_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {6'd0, out_pv_reg, out_pos_reg, out_flag_reg, out_rows_reg};
    assign m_tuser  = out_st_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

FILE: hdl/goi_ram.sv
`default_nettype none
module goi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire  logic                                 aclk,
    input  wire  logic                                 we,
    input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  logic [WIDTH-1:0]                     wdata,
    input  wire  logic                                 re,
    input  wire  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port; read data holds between reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;
    import goi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NGROUPS = 256;
    localparam int NPOS    = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] group_rows;
        logic        underrep;
        logic [31:0] boost_pos;
        logic        pos_valid;
        logic        last_flag;
    } result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [1:0]          s_tuser = CMD_CLEAR;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    group_occurrence_index_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow copy of the index
    logic [63:0] shadow_keys [NGROUPS];
    logic [31:0] shadow_rows [NGROUPS];
    int unsigned shadow_stored [NGROUPS];
    logic [31:0] shadow_positions [NGROUPS][NPOS];
    logic [31:0] shadow_total;
    int unsigned shadow_used;
    logic [4:0]  shadow_max_pos;
    logic [15:0] shadow_threshold;

    result_t     pending_results [$];
    bit          failed = 1'b0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    event        hold_request;
    bit          hold_active = 1'b0;
    logic [63:0] id_pool [12];

    // flag: exact integer comparison against threshold times expected count
    function automatic logic flag_for(logic [31:0] cnt, logic [31:0] obs,
                                      logic [31:0] samp);
        logic [127:0] share;
        logic [127:0] lhs;
        logic [127:0] rhs;
        if (shadow_total == 0 || samp == 0 || shadow_threshold == 0 || cnt == 0)
            return 1'b0;
        share = 128'(cnt) * 128'(samp);
        if ((share << 1) < 128'(shadow_total))
            return 1'b0;
        lhs = 128'(obs) * 128'(shadow_total) * 128'd4096;
        rhs = share * 128'(shadow_threshold);
        return lhs < rhs;
    endfunction

    function automatic void clear_shadow();
        shadow_total = 0;
        shadow_used  = 0;
        for (int g = 0; g < NGROUPS; g++) begin
            shadow_rows[g]   = 0;
            shadow_stored[g] = 0;
        end
    endfunction

    function automatic result_t make_result(logic [1:0] st, logic [31:0] rows,
                                            logic flag, logic [31:0] pos,
                                            logic pv, logic lst);
        result_t r;
        r.status = st; r.group_rows = rows; r.underrep = flag;
        r.boost_pos = pos; r.pos_valid = pv; r.last_flag = lst;
        return r;
    endfunction

    // append one expected result at the tail
    function automatic void queue_result(result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // work out the results one accepted item causes
    function automatic void predict_index(logic [1:0] cmd, logic [63:0] id,
                                          logic [31:0] pos, logic [31:0] obs,
                                          logic [31:0] samp, logic [15:0] boost);
        int g = -1;
        int unsigned cap;
        int unsigned take;
        for (int i = 0; i < shadow_used; i++)
            if (g < 0 && shadow_keys[i] == id) g = i;
        case (cmd)
            CMD_CLEAR: begin
                clear_shadow();
                queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
            end
            CMD_ADD: begin
                cap = (shadow_max_pos < NPOS) ? shadow_max_pos : NPOS;
                if (shadow_total != 32'hFFFF_FFFF) shadow_total++;
                if (g < 0 && shadow_used >= NGROUPS) begin
                    queue_result(make_result(ST_FULL, 0, 0, 0, 0, 1));
                end else begin
                    if (g < 0) begin
                        g = shadow_used;
                        shadow_keys[g] = id;
                        shadow_rows[g] = 0;
                        shadow_stored[g] = 0;
                        shadow_used++;
                    end
                    if (shadow_rows[g] != 32'hFFFF_FFFF) shadow_rows[g]++;
                    if (shadow_stored[g] < cap) begin
                        shadow_positions[g][shadow_stored[g]] = pos;
                        shadow_stored[g]++;
                    end
                    queue_result(make_result(ST_OK, shadow_rows[g], 0, 0, 0, 1));
                end
            end
            CMD_CHECK: begin
                if (g < 0)
                    queue_result(make_result(ST_NOTFOUND, 0, 0, 0, 0, 1));
                else
                    queue_result(make_result(ST_OK, shadow_rows[g],
                        flag_for(shadow_rows[g], obs, samp), 0, 0, 1));
            end
            default: begin
                if (g < 0) begin
                    queue_result(make_result(ST_NOTFOUND, 0, 0, 0, 0, 1));
                end else begin
                    take = shadow_stored[g];
                    if (boost < take) take = boost;
                    if (take == 0)
                        queue_result(make_result(ST_OK, 0, 0, 0, 0, 1));
                    for (int i = 0; i < take; i++)
                        queue_result(make_result(ST_OK, 0, 0,
                            shadow_positions[g][i], 1, i + 1 == take));
                end
            end
        endcase
    endfunction

    // offer one item in bursts with random gaps; predict on acceptance
    task automatic send_item(logic [1:0] cmd, logic [63:0] id, logic [31:0] pos,
                             logic [31:0] obs, logic [31:0] samp, logic [15:0] boost);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {boost, samp, obs, pos, id};
        do @(posedge aclk); while (!s_tready);
        predict_index(cmd, id, pos, obs, samp, boost);
    endtask

    // wait until every expected result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_MAX_POS) shadow_max_pos = value[4:0];
        else shadow_threshold = value[15:0];
    endtask

    // long hold-off, counted here in cycles
    always begin
        @(hold_request);
        hold_active = 1'b1;
        repeat (400) @(posedge aclk);
        hold_active = 1'b0;
    end

    // receiver: long hold-off on request, else a stall pattern of its own
    always @(posedge aclk) begin
        if (hold_active) begin
            m_tready <= 1'b0;
        end else if (cycle_count[9:8] == 2'b01) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= $urandom_range(0, 2) != 0;
        end
    end

    // compare each result with the oldest expectation
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item status=%0d", m_tuser);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d actual %0d", want.status, m_tuser);
                    failed = 1'b1;
                end
                if (m_tdata[31:0] !== want.group_rows) begin
                    $error("group_rows: expected %0d actual %0d",
                           want.group_rows, m_tdata[31:0]);
                    failed = 1'b1;
                end
                if (m_tdata[32] !== want.underrep) begin
                    $error("underrepresented: expected %0d actual %0d",
                           want.underrep, m_tdata[32]);
                    failed = 1'b1;
                end
                if (m_tdata[64:33] !== want.boost_pos) begin
                    $error("boost_position: expected %h actual %h",
                           want.boost_pos, m_tdata[64:33]);
                    failed = 1'b1;
                end
                if (m_tdata[65] !== want.pos_valid) begin
                    $error("position_valid: expected %0d actual %0d",
                           want.pos_valid, m_tdata[65]);
                    failed = 1'b1;
                end
                if (m_tlast !== want.last_flag) begin
                    $error("last: expected %0d actual %0d", want.last_flag, m_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // field extremes, each command and the special cases
    task automatic test_directed();
        send_item(CMD_FETCH, 64'h0, 32'h0, 0, 0, 16'hFFFF);
        send_item(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 18; i++)
            send_item(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFFF, i[0] ? 32'hFFFF_FFFF : 32'(i),
                      0, 0, 0);
        send_item(CMD_ADD, 64'h0, 32'h0, 0, 0, 0);
        send_item(CMD_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 16'hFFFF);
        send_item(CMD_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 16'd0);
        send_item(CMD_FETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 16'd3);
        send_item(CMD_CHECK, 64'h0, 0, 32'd0, 32'd19, 0);
        send_item(CMD_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32'd0, 32'd19, 0);
        send_item(CMD_CLEAR, 64'h0, 0, 0, 0, 0);
        send_item(CMD_FETCH, 64'h0, 0, 0, 0, 16'd1);
        wait_idle();
    endtask

    // register sweep: store limits and thresholds, extremes included
    task automatic test_register_sweep();
        logic [31:0] max_values [4] = '{32'd0, 32'd5, 32'd31, 32'd16};
        logic [31:0] thr_values [4] = '{32'd0, 32'd65535, 32'd2048, 32'd4096};
        for (int k = 0; k < 4; k++) begin
            write_reg(REG_MAX_POS, max_values[k]);
            write_reg(REG_THRESHOLD, thr_values[k]);
            send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
            for (int i = 0; i < 16; i++)
                send_item(CMD_ADD, id_pool[i % 3], $urandom, 0, 0, 0);
            for (int i = 0; i < 3; i++) begin
                send_item(CMD_CHECK, id_pool[i], 0, $urandom_range(0, 8), 20, 0);
                send_item(CMD_FETCH, id_pool[i], 0, 0, 0, 16'd20);
            end
            wait_idle();
        end
        // lowered limit keeps what is stored
        write_reg(REG_MAX_POS, 32'd2);
        send_item(CMD_ADD, id_pool[0], $urandom, 0, 0, 0);
        send_item(CMD_FETCH, id_pool[0], 0, 0, 0, 16'd16);
        wait_idle();
        write_reg(REG_MAX_POS, 32'd16);
        write_reg(REG_THRESHOLD, 32'd4096);
    endtask

    // fill every group, then a new group finds the table full
    task automatic test_full_table();
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        for (int i = 0; i < NGROUPS; i++)
            send_item(CMD_ADD, {32'hA5A5_0000, 32'(i)}, $urandom, 0, 0, 0);
        send_item(CMD_ADD, 64'hDEAD_0000_0000_0001, $urandom, 0, 0, 0);
        send_item(CMD_ADD, {32'hA5A5_0000, 32'd255}, $urandom, 0, 0, 0);
        send_item(CMD_CHECK, 64'hDEAD_0000_0000_0001, 0, 1, 1, 0);
        send_item(CMD_CHECK, {32'hA5A5_0000, 32'd255}, 0, 0, 200, 0);
        send_item(CMD_FETCH, {32'hA5A5_0000, 32'd255}, 0, 0, 0, 16'd4);
        send_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        wait_idle();
    endtask

    // random commands over a small set of groups
    task automatic test_random(int unsigned count);
        logic [63:0] id;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                             : id_pool[$urandom_range(0, 11)];
            pick = $urandom_range(0, 99);
            if (pick < 2)
                send_item(CMD_CLEAR, id, $urandom, $urandom, $urandom, 16'($urandom));
            else if (pick < 52)
                send_item(CMD_ADD, id, $urandom, $urandom, $urandom, 16'($urandom));
            else if (pick < 77)
                send_item(CMD_CHECK, id, $urandom,
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40),
                          $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 300),
                          16'($urandom));
            else
                send_item(CMD_FETCH, id, $urandom, $urandom, $urandom,
                          $urandom_range(0, 4) == 0 ? 16'($urandom)
                                                    : 16'($urandom_range(0, 20)));
        end
        wait_idle();
    endtask

    // receiver holds off while items keep coming
    task automatic test_backpressure();
        -> hold_request;
        for (int i = 0; i < 12; i++)
            send_item(CMD_ADD, id_pool[0], $urandom, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_item(CMD_FETCH, id_pool[0], 0, 0, 0, 16'd16);
        wait_idle();
    endtask

    initial begin
        clear_shadow();
        shadow_max_pos   = 5'd16;
        shadow_threshold = 16'd4096;
        id_pool[0] = 64'h0;
        id_pool[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 2; i < 12; i++) id_pool[i] = {$urandom, $urandom};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_directed();
        test_register_sweep();
        test_full_table();
        test_backpressure();
        write_reg(REG_THRESHOLD, 32'd6000);
        test_random(40);
        repeat (50) @(posedge aclk);
        if (!failed && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
